[hw/rtl/pwmfb_pkg.sv]
// Shared types, constants and helper functions for the PWM diagnostic feedback generator.
`default_nettype none

package pwmfb_pkg;

   // Width of every internal time value (timer, phase ends, latched limits).
   localparam int TIME_BITS = 16;
   // Common width that holds both a 16-bit field and a time value.
   localparam int WIDE_BITS = (TIME_BITS > 16) ? TIME_BITS : 16;
   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   localparam int FIELD_BITS     = 16;
   localparam int STEP_BITS      = 8;
   localparam int CFG_INDEX_BITS = 3;
   localparam int CFG_DATA_BITS  = 16;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      CFG_PERIOD_TIME        = 3'd0,
      CFG_HIGH_TIME          = 3'd1,
      CFG_TICK_STEP          = 3'd2,
      CFG_POWERON_DELAY      = 3'd3,
      CFG_OVERVOLTAGE_LIMIT  = 3'd4,
      CFG_UNDERVOLTAGE_LIMIT = 3'd5
   } cfg_index_type;

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   typedef struct packed {
      field_type              period_time;
      field_type              high_time;
      logic [STEP_BITS-1:0]   tick_step;
      field_type              poweron_delay;
      field_type              overvoltage_limit;
      field_type              undervoltage_limit;
   } cfg_type;

   typedef struct packed {
      field_type low_time_request;
      field_type supply_voltage;
      logic      enable_line_high;
      field_type target_speed;
   } req_type;

   typedef struct packed {
      logic      pin_high;
      logic      pulldown_on;
      field_type held_low_time;
      field_type current_high_phase;
      field_type current_cycle_end;
      field_type current_low_time;
   } rsp_type;

   // Saturates a 16-bit field into the time width.
   function automatic time_type to_time(input field_type v);
      logic [WIDE_BITS-1:0] w;
      w = WIDE_BITS'(v);
      if (w > WIDE_BITS'(TIME_MAX)) begin
         return TIME_MAX;
      end
      return TIME_BITS'(w);
   endfunction

   // Saturating add of two time values.
   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TIME_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[TIME_BITS]) begin
         return TIME_MAX;
      end
      return s[TIME_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

[hw/rtl/pwmfb_csr.sv]
// Configuration register file of the PWM diagnostic feedback generator.
`default_nettype none

module pwmfb_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   input  wire logic [pwmfb_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  wire logic [pwmfb_pkg::CFG_DATA_BITS-1:0]  csr_wdata,
   output pwmfb_pkg::cfg_type                        cfg
);
   import pwmfb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CFG_PERIOD_TIME:        cfg_in.period_time        = csr_wdata;
            CFG_HIGH_TIME:          cfg_in.high_time          = csr_wdata;
            CFG_TICK_STEP:          cfg_in.tick_step          = csr_wdata[STEP_BITS-1:0];
            CFG_POWERON_DELAY:      cfg_in.poweron_delay      = csr_wdata;
            CFG_OVERVOLTAGE_LIMIT:  cfg_in.overvoltage_limit  = csr_wdata;
            CFG_UNDERVOLTAGE_LIMIT: cfg_in.undervoltage_limit = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_time        <= '0;
         cfg_ff.high_time          <= '0;
         cfg_ff.tick_step          <= STEP_BITS'(10);
         cfg_ff.poweron_delay      <= '0;
         cfg_ff.overvoltage_limit  <= '1;
         cfg_ff.undervoltage_limit <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/pwmfb_core.sv]
// Per-tick state and feedback computation of the PWM diagnostic feedback generator.
`default_nettype none

module pwmfb_core (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fire,
   input  pwmfb_pkg::cfg_type cfg,
   input  pwmfb_pkg::req_type item,
   output pwmfb_pkg::rsp_type result
);
   import pwmfb_pkg::*;

   time_type  phase_timer_ff, phase_timer_in;
   logic      round_latched_ff, round_latched_in;
   time_type  latched_high_end_ff, latched_high_end_in;
   time_type  latched_cycle_end_ff, latched_cycle_end_in;
   logic      poweron_done_ff, poweron_done_in;
   field_type poweron_count_ff, poweron_count_in;
   time_type  kept_low_time_ff, kept_low_time_in;

   time_type           low_req, low_eff, per, hi, high_phase, cycle_end, timer_sum, timer_base;
   logic [FIELD_BITS:0] count_next;
   logic               suppress, latched_base, pin;

   always_comb begin
      low_req = to_time(item.low_time_request);
      per     = to_time(cfg.period_time);
      hi      = to_time(cfg.high_time);

      kept_low_time_in = (low_req != '0) ? low_req : kept_low_time_ff;

      // Power-on delay counter, compared one bit wider so an all-ones delay ends.
      count_next       = {1'b0, poweron_count_ff} + (FIELD_BITS+1)'(1);
      poweron_done_in  = poweron_done_ff;
      poweron_count_in = poweron_count_ff;
      if (!poweron_done_ff) begin
         if (count_next > {1'b0, cfg.poweron_delay}) begin
            poweron_count_in = '0;
            poweron_done_in  = 1'b1;
         end else begin
            poweron_count_in = count_next[FIELD_BITS-1:0];
         end
      end

      suppress = (item.supply_voltage > cfg.overvoltage_limit) || !poweron_done_in
               || (item.supply_voltage < cfg.undervoltage_limit)
               || !item.enable_line_high || (item.target_speed == '0);

      low_eff      = suppress ? '0 : low_req;
      latched_base = suppress ? 1'b0 : round_latched_ff;
      timer_base   = suppress ? '0 : phase_timer_ff;

      if (per != '0) begin
         high_phase = (per > low_eff) ? per - low_eff : '0;
         cycle_end  = per;
      end else begin
         high_phase = hi;
         cycle_end  = sat_add(hi, low_eff);
      end

      latched_high_end_in  = latched_base ? latched_high_end_ff  : high_phase;
      latched_cycle_end_in = latched_base ? latched_cycle_end_ff : cycle_end;

      timer_sum        = sat_add(timer_base, TIME_BITS'(cfg.tick_step));
      phase_timer_in   = timer_sum;
      round_latched_in = 1'b1;
      pin              = 1'b1;
      if (timer_sum >= latched_high_end_in) begin
         if (timer_sum < latched_cycle_end_in) begin
            pin = 1'b0;
         end else begin
            round_latched_in = 1'b0;
            kept_low_time_in = '0;
            phase_timer_in   = '0;
         end
      end

      result.pin_high           = pin;
      result.pulldown_on        = !pin;
      result.held_low_time      = FIELD_BITS'(kept_low_time_in);
      result.current_high_phase = FIELD_BITS'(high_phase);
      result.current_cycle_end  = FIELD_BITS'(cycle_end);
      result.current_low_time   = FIELD_BITS'(low_eff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_timer_ff       <= '0;
         round_latched_ff     <= 1'b0;
         latched_high_end_ff  <= '0;
         latched_cycle_end_ff <= '0;
         poweron_done_ff      <= 1'b0;
         poweron_count_ff     <= '0;
         kept_low_time_ff     <= '0;
      end else if (fire) begin
         phase_timer_ff       <= phase_timer_in;
         round_latched_ff     <= round_latched_in;
         latched_high_end_ff  <= latched_high_end_in;
         latched_cycle_end_ff <= latched_cycle_end_in;
         poweron_done_ff      <= poweron_done_in;
         poweron_count_ff     <= poweron_count_in;
         kept_low_time_ff     <= kept_low_time_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/pwm_diagnostic_feedback_generator_top.sv]
// Top level of the PWM diagnostic feedback generator: handshakes, pipeline registers and checks.
// A tick transaction accepted at one edge is registered in the input stage, then computed and
// registered in the result stage once that register is empty or its result is taken by rsp_ready.
// Throughput: one tick per cycle while rsp_ready is high; input stage and result register each
// hold one item, so an empty input stage still takes a tick while a result waits for rsp_ready.
// Reset (synchronous, active high) empties both stages, clears all feedback state to zero and
// loads the configuration reset values; the block is ready for ticks once reset is released.
`default_nettype none

module pwm_diagnostic_feedback_generator_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [15:0]                          req_low_time_request,
   input  wire logic [15:0]                          req_supply_voltage,
   input  wire logic                                 req_enable_line_high,
   input  wire logic [15:0]                          req_target_speed,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_pin_high,
   output logic                                      rsp_pulldown_on,
   output logic [15:0]                               rsp_held_low_time,
   output logic [15:0]                               rsp_current_high_phase,
   output logic [15:0]                               rsp_current_cycle_end,
   output logic [15:0]                               rsp_current_low_time,

   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [pwmfb_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  wire logic [pwmfb_pkg::CFG_DATA_BITS-1:0]  csr_wdata
);
   import pwmfb_pkg::*;

   // The register file takes a write transaction in every cycle.
   assign csr_ready = 1'b1;

   cfg_type cfg;

   pwmfb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Input stage: one tick waits here until the result register can take its result.
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   rsp_type core_result;
   logic    advance;

   // The tick moves into the result register, and the feedback state steps, at the same edge.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in                 = 1'b1;
         in_item_in.low_time_request = req_low_time_request;
         in_item_in.supply_voltage   = req_supply_voltage;
         in_item_in.enable_line_high = req_enable_line_high;
         in_item_in.target_speed     = req_target_speed;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_result;
      end
   end

   pwmfb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset; their valid flags qualify them.
   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_pin_high           = rsp_ff.pin_high;
   assign rsp_pulldown_on        = rsp_ff.pulldown_on;
   assign rsp_held_low_time      = rsp_ff.held_low_time;
   assign rsp_current_high_phase = rsp_ff.current_high_phase;
   assign rsp_current_cycle_end  = rsp_ff.current_cycle_end;
   assign rsp_current_low_time   = rsp_ff.current_low_time;

   // A tick that leaves the input stage always shows up as a valid result next cycle.
   a_advance_gives_result : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced tick did not produce a result");

   // A waiting result is never dropped before it is taken.
   a_result_kept : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready && !advance) |=> (rsp_valid_ff && $stable(rsp_ff)))
      else $error("stalled result was lost or changed");

   // The pull-down is on exactly when the pin is driven low.
   a_pulldown_follows_pin : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pulldown_on != rsp_pin_high))
      else $error("pull-down does not follow the pin");

   // With the input stage empty, a new tick is always taken.
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input stage empty but not ready");

endmodule

`default_nettype wire
